// ===== src/rdrl_pkg.sv =====
// package for the recurrent delta-rule layer: sizes, fixed-point constants, helpers
// no dependencies
package rdrl_pkg;

    localparam int NUM_UNITS   = 7;
    localparam int NUM_PIXELS  = 7;
    localparam int PIX_IDX_W   = 3;
    localparam int SCORE_W     = 19;
    localparam int WEIGHT_W    = 32;
    localparam int LR_W        = 24;
    localparam int CLASS_W     = 3;
    localparam int ACC_W       = 44;
    localparam int DY_W        = 20;
    localparam int LRDY_W      = 45;

    localparam logic [15:0] SCALE_MILLI = 16'd16777;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [LR_W-1:0] LR_RESET = 24'd16777;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // lane control from the sequencer
    typedef struct packed {
        logic                 clear;
        logic                 mac_en;
        logic [PIX_IDX_W-1:0] mac_idx;
        logic                 fwd_en;
        logic                 upd_en;
        logic [PIX_IDX_W-1:0] upd_idx;
        logic                 upd_bias;
        logic                 eos_clr;
    } t_lane_ctrl;

    // saturate a signed value to the signed 32-bit range
    function automatic logic signed [WEIGHT_W-1:0] sat32(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sh0000_7FFF_FFFF;
        lo = -48'sh0000_8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[WEIGHT_W-1:0];
        end
    endfunction

    // piecewise-linear sigmoid, Q.16 in, Q0.16 out
    function automatic logic [15:0] sigmoid_q16(input logic signed [47:0] z);
        logic [47:0] a;
        logic [16:0] y;
        a = z[47] ? 48'(-z) : 48'(z);
        if (a >= 48'd327680) begin
            y = ONE_Q16;
        end else if (a >= 48'd155648) begin
            y = 17'(a >> 5) + 17'd55296;
        end else if (a >= 48'd65536) begin
            y = 17'(a >> 3) + 17'd40960;
        end else begin
            y = 17'(a >> 2) + 17'd32768;
        end
        if (z[47]) begin
            y = ONE_Q16 - y;
        end
        sigmoid_q16 = y[16] ? 16'hFFFF : y[15:0];
    endfunction

endpackage

// ===== src/rdrl_lane.sv =====
// one unit lane: serial multiply-accumulate, sigmoid, memory and weight update
// depends on rdrl_pkg
module rdrl_lane
    import rdrl_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_lane_ctrl                  i_ctrl,
    input  logic [NUM_PIXELS-1:0][7:0]  i_pix,
    input  logic                        i_hot,
    input  logic [LR_W-1:0]             i_lr,
    output logic [SCORE_W-1:0]          o_score
);

    logic signed [WEIGHT_W-1:0] r_w [NUM_PIXELS];
    logic signed [WEIGHT_W-1:0] r_bias;
    logic [SCORE_W-1:0]         r_mem;
    logic [SCORE_W-1:0]         r_score;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [LRDY_W-1:0]   r_lrdy;
    logic [1:0]                 r_phase;

    logic signed [40:0]         prod;
    logic signed [ACC_W+16:0]   scaled;
    logic signed [47:0]         z;
    logic [SCORE_W:0]           n_score;
    logic signed [DY_W-1:0]     dy;
    logic signed [LRDY_W+8:0]   step;
    logic signed [47:0]         step_sh;
    logic [7:0]                 upd_pix;

    // one weight times one pixel per cycle
    assign prod = r_w[i_ctrl.mac_idx] * $signed({1'b0, i_pix[i_ctrl.mac_idx]});

    // forward: scale, add bias, sigmoid, add memory
    assign scaled  = r_acc * $signed({1'b0, SCALE_MILLI});
    assign z       = 48'(r_bias) + 48'(scaled >>> 24);
    assign n_score = {4'd0, sigmoid_q16(z)} + {1'b0, r_mem};

    // update term; bias step uses pixel of one
    assign dy      = $signed({3'd0, i_hot, 16'd0}) - $signed({1'b0, r_score});
    assign upd_pix = i_ctrl.upd_bias ? 8'd1 : i_pix[i_ctrl.upd_idx];
    assign step    = r_lrdy * $signed({1'b0, upd_pix});
    assign step_sh = 48'(step >>> 24);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PIXELS; k++) begin
                r_w[k] <= '0;
            end
            r_bias  <= '0;
            r_mem   <= '0;
            r_score <= '0;
            r_acc   <= '0;
            r_lrdy  <= '0;
            r_phase <= '0;
        end else begin
            if (i_ctrl.clear) begin
                r_acc <= '0;
            end else if (i_ctrl.mac_en) begin
                r_acc <= r_acc + ACC_W'(prod);
            end
            if (i_ctrl.fwd_en) begin
                r_score <= n_score[SCORE_W] ? SCORE_MAX : n_score[SCORE_W-1:0];
                r_mem   <= n_score[SCORE_W] ? SCORE_MAX : n_score[SCORE_W-1:0];
                r_phase <= 2'd1;
            end else if (r_phase == 2'd1) begin
                // registered product of rate and error
                r_lrdy  <= $signed({1'b0, i_lr}) * dy;
                r_phase <= 2'd0;
            end
            if (i_ctrl.upd_en) begin
                if (i_ctrl.upd_bias) begin
                    r_bias <= sat32(48'(r_bias) + step_sh);
                end else begin
                    r_w[i_ctrl.upd_idx] <= sat32(48'(r_w[i_ctrl.upd_idx]) + step_sh);
                end
            end
            if (i_ctrl.eos_clr) begin
                r_mem <= '0;
            end
        end
    end

    assign o_score = r_score;

endmodule

// ===== src/rdrl_merge.sv =====
// merging stage: first-maximum search over lane scores and correctness flag
// depends on rdrl_pkg
module rdrl_merge
    import rdrl_pkg::*;
(
    input  logic [NUM_UNITS-1:0][SCORE_W-1:0] i_scores,
    input  logic [CLASS_W-1:0]                i_target,
    output logic [CLASS_W-1:0]                o_best,
    output logic                              o_correct
);

    logic [SCORE_W-1:0] best_val;
    logic [CLASS_W-1:0] best_idx;

    // strict compare keeps the first maximum
    always_comb begin
        best_val = i_scores[0];
        best_idx = '0;
        for (int u = 1; u < NUM_UNITS; u++) begin
            if (i_scores[u] > best_val) begin
                best_val = i_scores[u];
                best_idx = CLASS_W'(u);
            end
        end
    end

    assign o_best    = best_idx;
    assign o_correct = (best_idx == i_target);

endmodule

// ===== src/recurrent_delta_rule_layer_unit.sv =====
// top level of the recurrent delta-rule layer: sequencer, lanes, merge, output register
// depends on rdrl_pkg, rdrl_lane, rdrl_merge
//
// usage:
//  input channel i_valid/o_ready carries seven pixel bytes, target class, train
//  and end-of-sequence flags; output channel o_valid/i_ready carries seven
//  scores, predicted class and correct flag, one result per transaction.
//  seven unit lanes run in parallel, each with one mac multiplier stepping over the
//  seven pixels; the weight update walks the same seven weights plus the bias.
//  steps from accept to o_valid: mac over the seven pixels, sigmoid, rate
//  product, update pass. without train the update pass still runs, so the work
//  is the same for every transaction.
//  throughput: one transaction in work at a time; o_ready rises in the idle
//  cycle after the result is registered; none is taken before the last is done.
//  learn rate written by i_cfg_we/i_cfg_data only while idle: a user rule, not enforced.
//  reset: synchronous active-low, clears weights, biases, memory, learn rate to
//  default; no clearing pass.
//  stalled receiver: result holds in the output register until taken; the next
//  transaction is still accepted and worked, and waits in its last update cycle
//  until the output register is free.
module recurrent_delta_rule_layer_unit
    import rdrl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_pixel_0,
    input  logic [7:0]         i_pixel_1,
    input  logic [7:0]         i_pixel_2,
    input  logic [7:0]         i_pixel_3,
    input  logic [7:0]         i_pixel_4,
    input  logic [7:0]         i_pixel_5,
    input  logic [7:0]         i_pixel_6,
    input  logic [2:0]         i_target_class,
    input  logic               i_train,
    input  logic               i_end_of_sequence,
    input  logic               i_cfg_we,
    input  logic [LR_W-1:0]    i_cfg_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SCORE_W-1:0] o_score_0,
    output logic [SCORE_W-1:0] o_score_1,
    output logic [SCORE_W-1:0] o_score_2,
    output logic [SCORE_W-1:0] o_score_3,
    output logic [SCORE_W-1:0] o_score_4,
    output logic [SCORE_W-1:0] o_score_5,
    output logic [SCORE_W-1:0] o_score_6,
    output logic [2:0]         o_predicted_class,
    output logic               o_prediction_correct
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MAC  = 5'b00010,
        ST_FWD  = 5'b00100,
        ST_RATE = 5'b01000,
        ST_UPD  = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [PIX_IDX_W:0]           r_cnt;
    logic [NUM_PIXELS-1:0][7:0]   r_pix;
    logic [CLASS_W-1:0]           r_target;
    logic                         r_train;
    logic                         r_eos;
    logic [LR_W-1:0]              r_lr;
    logic                         r_out_valid;
    logic [NUM_UNITS-1:0][SCORE_W-1:0] r_out_score;
    logic [CLASS_W-1:0]           r_out_class;
    logic                         r_out_correct;

    t_lane_ctrl                   ctrl;
    logic [NUM_UNITS-1:0][SCORE_W-1:0] scores;
    logic [CLASS_W-1:0]           best;
    logic                         correct;
    logic                         in_acc;
    logic                         last;
    logic                         out_free;
    logic                         done;

    assign o_ready  = (r_state == ST_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign last     = (r_state == ST_UPD) && (r_cnt == (PIX_IDX_W+1)'(NUM_PIXELS));
    assign out_free = !r_out_valid || i_ready;
    assign done     = last && out_free;

    // sequencer control to the lanes
    always_comb begin
        ctrl          = '0;
        ctrl.clear    = in_acc;
        ctrl.mac_en   = (r_state == ST_MAC);
        ctrl.mac_idx  = r_cnt[PIX_IDX_W-1:0];
        ctrl.fwd_en   = (r_state == ST_FWD);
        ctrl.upd_en   = (r_state == ST_UPD) && r_train && (!last || out_free);
        ctrl.upd_idx  = r_cnt[PIX_IDX_W-1:0];
        ctrl.upd_bias = (r_cnt == (PIX_IDX_W+1)'(NUM_PIXELS));
        ctrl.eos_clr  = done && r_eos;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_MAC;
            ST_MAC:  if (r_cnt == (PIX_IDX_W+1)'(NUM_PIXELS - 1)) n_state = ST_FWD;
            ST_FWD:  n_state = ST_RATE;
            ST_RATE: n_state = ST_UPD;
            ST_UPD:  if (done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state, counter, captured transaction and learn rate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_lr    <= LR_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_lr <= i_cfg_data;
            end
            if (n_state != r_state || r_state == ST_IDLE) begin
                r_cnt <= '0;
            end else if (!last) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix    <= {i_pixel_6, i_pixel_5, i_pixel_4, i_pixel_3,
                         i_pixel_2, i_pixel_1, i_pixel_0};
            r_target <= i_target_class;
            r_train  <= i_train;
            r_eos    <= i_end_of_sequence;
        end
    end

    // unit lanes
    for (genvar u = 0; u < NUM_UNITS; u++) begin : g_lane
        rdrl_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_pix   (r_pix),
            .i_hot   (r_target == CLASS_W'(u)),
            .i_lr    (r_lr),
            .o_score (scores[u])
        );
    end

    rdrl_merge u_merge (
        .i_scores  (scores),
        .i_target  (r_target),
        .o_best    (best),
        .o_correct (correct)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_score   <= scores;
            r_out_class   <= best;
            r_out_correct <= correct;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_score_0            = r_out_score[0];
    assign o_score_1            = r_out_score[1];
    assign o_score_2            = r_out_score[2];
    assign o_score_3            = r_out_score[3];
    assign o_score_4            = r_out_score[4];
    assign o_score_5            = r_out_score[5];
    assign o_score_6            = r_out_score[6];
    assign o_predicted_class    = r_out_class;
    assign o_prediction_correct = r_out_correct;

endmodule
